@@ hdl/dcpd_pkg.sv @@
// Shared types and constants of the delay-and-correlate preamble detector.
// Used by dcpd_ctrl, dcpd_datapath and the top level; depends on nothing.
package dcpd_pkg;

  // Fixed field widths
  localparam int unsigned WIN_W      = 7;
  localparam int unsigned LAG_W      = 7;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned ML_W       = 29;
  localparam int unsigned HOLD_W     = 12;
  localparam int unsigned PLEN_W     = 16;
  localparam int unsigned METRIC_W   = 16;
  localparam int unsigned Q_FRAC     = 12;
  localparam int unsigned SAT_SH     = METRIC_W - Q_FRAC;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(METRIC_W);

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LEN  = 3'd5;

  typedef struct packed {
    logic [WIN_W-1:0]  window_len;
    logic [LAG_W-1:0]  lag;
    logic [THR_W-1:0]  threshold;
    logic [ML_W-1:0]   min_level;
    logic [HOLD_W-1:0] holdoff_len;
    logic [PLEN_W-1:0] pkt_len_total;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // store sample, set up read pointers, clear sums
    logic rd_en;     // read one history pair
    logic square;    // form the squares
    logic sum;       // form |C|^2 and E^2
    logic div_init;  // limit checks, load divider
    logic div_step;  // one quotient bit
    logic load_out;  // load result register, update holdoff
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_last;
    logic div_last;
  } status_t;

endpackage

@@ hdl/dcpd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dcpd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/dcpd_ctrl.sv @@
// Sequencing state machine of the preamble detector.
// Depends on dcpd_pkg; drives dcpd_datapath through cmd_t / status_t.
module dcpd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output dcpd_pkg::cmd_t    cmd_o,
  input  dcpd_pkg::status_t status_i
);
  import dcpd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_full_q, out_full_d;
  logic       in_accept;

  assign s_tready_o = (state_q == S_IDLE);
  assign in_accept  = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = out_full_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_o.start = 1'b1;
          state_d     = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.rd_last) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_SQ;
      S_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = S_ADD;
      end
      S_ADD: begin
        cmd_o.sum = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_OUT;
      end
      S_OUT: begin
        // result register must be free or emptying this cycle
        if (!out_full_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_full_d = out_full_q;
    if (cmd_o.load_out) begin
      out_full_d = 1'b1;
    end else if (m_tready_i) begin
      out_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      out_full_q <= out_full_d;
    end
  end

  a_accept_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_RD)
    else $error("accepted item did not start the history read");

  a_load_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_full_q)
    else $error("result load did not mark output register full");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_full_q && !m_tready_i) |-> !cmd_o.load_out)
    else $error("result overwritten while waiting");

  a_div_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD && status_i.rd_last) |=> state_q == S_DRAIN)
    else $error("read phase did not end on last pair");

endmodule

@@ hdl/dcpd_datapath.sv @@
// History memories, correlation/energy accumulators, squaring, metric divider,
// holdoff counter and result register. Depends on dcpd_pkg and dcpd_ram.
module dcpd_datapath #(
  parameter int unsigned MAX_WINDOW    = 64,
  parameter int unsigned MAX_LAG       = 64,
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dcpd_pkg::cfg_t                    cfg_i,
  input  dcpd_pkg::cmd_t                    cmd_i,
  output dcpd_pkg::status_t                 status_o,
  input  logic [SAMPLE_BITS-1:0]            clean_i_i,
  input  logic [SAMPLE_BITS-1:0]            clean_q_i,
  input  logic [SAMPLE_BITS-1:0]            raw_i_i,
  input  logic [SAMPLE_BITS-1:0]            raw_q_i,
  output logic [SAMPLE_BITS-1:0]            out_i_o,
  output logic [SAMPLE_BITS-1:0]            out_q_o,
  output logic [dcpd_pkg::METRIC_W-1:0]     metric_o,
  output logic                              detected_o,
  output logic [dcpd_pkg::PLEN_W-1:0]       pkt_len_o
);
  import dcpd_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned AW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned EN_W  = 2 * SB + $clog2(MAX_WINDOW);
  localparam int unsigned CR_W  = EN_W + 1;
  localparam int unsigned SQ_W  = 2 * EN_W;
  localparam int unsigned MG_W  = SQ_W + 1;
  localparam int unsigned DV_W  = SQ_W + METRIC_W;
  localparam int unsigned ML2_W = 2 * ML_W;

  function automatic logic [AW-1:0] inc_mod(input logic [AW-1:0] x);
    logic [AW-1:0] r;
    r = (x == AW'(HISTORY_DEPTH - 1)) ? '0 : x + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] x, input logic [AW-1:0] y);
    logic [AW:0] diff;
    diff = {1'b0, x} - {1'b0, y};
    if (diff[AW]) diff = diff + (AW+1)'(HISTORY_DEPTH);
    return diff[AW-1:0];
  endfunction

  // Effective window and lag after clamping
  int            l_int, d_int;
  logic [AW-1:0] win_len, t_len;

  always_comb begin
    l_int = int'(cfg_i.window_len);
    if (l_int < 1) l_int = 1;
    if (l_int > int'(MAX_WINDOW)) l_int = int'(MAX_WINDOW);
    if (l_int > int'(HISTORY_DEPTH) - 1) l_int = int'(HISTORY_DEPTH) - 1;
    d_int = int'(cfg_i.lag);
    if (d_int < 1) d_int = 1;
    if (d_int > int'(MAX_LAG)) d_int = int'(MAX_LAG);
    if (d_int > int'(HISTORY_DEPTH) - l_int) d_int = int'(HISTORY_DEPTH) - l_int;
    win_len = AW'(l_int);
    t_len   = AW'(l_int + d_int - 1);
  end

  // Write pointer, read pointers, pair counter, valid bits
  logic [AW-1:0]            wr_q, wr_next, a_q, b_q, k_q;
  logic [HISTORY_DEPTH-1:0] valid_q;
  logic                     va_q, vb_q, acc_q, first_q;

  assign wr_next          = inc_mod(wr_q);
  assign status_o.rd_last = (k_q == win_len - AW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      valid_q <= '0;
      acc_q   <= 1'b0;
      first_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        wr_q             <= wr_next;
        valid_q[wr_next] <= 1'b1;
      end
      acc_q   <= cmd_i.rd_en;
      first_q <= cmd_i.rd_en && (k_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q <= sub_mod(wr_next, t_len);
      b_q <= sub_mod(wr_next, win_len - AW'(1));
      k_q <= '0;
    end else if (cmd_i.rd_en) begin
      a_q <= inc_mod(a_q);
      b_q <= inc_mod(b_q);
      k_q <= k_q + AW'(1);
    end
    va_q <= valid_q[a_q];
    vb_q <= valid_q[b_q];
  end

  // History memories: clean copy per read address, one raw
  logic [2*SB-1:0] clean_wdata, raw_wdata, ra_data, rb_data, raw_data;

  assign clean_wdata = {clean_q_i, clean_i_i};
  assign raw_wdata   = {raw_q_i, raw_i_i};

  dcpd_ram #(.WIDTH(2*SB), .DEPTH(HISTORY_DEPTH)) u_clean_a (
    .clk_i, .we_i(cmd_i.start), .waddr_i(wr_next), .wdata_i(clean_wdata),
    .re_i(cmd_i.rd_en), .raddr_i(a_q), .rdata_o(ra_data)
  );

  dcpd_ram #(.WIDTH(2*SB), .DEPTH(HISTORY_DEPTH)) u_clean_b (
    .clk_i, .we_i(cmd_i.start), .waddr_i(wr_next), .wdata_i(clean_wdata),
    .re_i(cmd_i.rd_en), .raddr_i(b_q), .rdata_o(rb_data)
  );

  dcpd_ram #(.WIDTH(2*SB), .DEPTH(HISTORY_DEPTH)) u_raw (
    .clk_i, .we_i(cmd_i.start), .waddr_i(wr_next), .wdata_i(raw_wdata),
    .re_i(cmd_i.rd_en), .raddr_i(a_q), .rdata_o(raw_data)
  );

  // Never-written entries read as zero
  logic signed [SB-1:0]   ai, aq, bi, bq;
  logic signed [2*SB-1:0] p_aibi, p_aqbq, p_aqbi, p_aibq, p_bibi, p_bqbq;

  assign ai = va_q ? signed'(ra_data[SB-1:0])    : '0;
  assign aq = va_q ? signed'(ra_data[2*SB-1:SB]) : '0;
  assign bi = vb_q ? signed'(rb_data[SB-1:0])    : '0;
  assign bq = vb_q ? signed'(rb_data[2*SB-1:SB]) : '0;

  assign p_aibi = ai * bi;
  assign p_aqbq = aq * bq;
  assign p_aqbi = aq * bi;
  assign p_aibq = ai * bq;
  assign p_bibi = bi * bi;
  assign p_bqbq = bq * bq;

  // Sums: C = sum a*conj(b), E = sum |b|^2
  logic signed [CR_W-1:0] cr_q, ci_q;
  logic [EN_W-1:0]        en_q;
  logic [2*SB-1:0]        raw_hold_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cr_q <= '0;
      ci_q <= '0;
      en_q <= '0;
    end else if (acc_q) begin
      cr_q <= cr_q + CR_W'(p_aibi) + CR_W'(p_aqbq);
      ci_q <= ci_q + CR_W'(p_aqbi) - CR_W'(p_aibq);
      en_q <= en_q + EN_W'($unsigned(p_bibi)) + EN_W'($unsigned(p_bqbq));
    end
    if (first_q) begin
      raw_hold_q <= va_q ? raw_data : '0;
    end
  end

  // Squares, then |C|^2 and E^2
  logic [CR_W-1:0]  cr_abs, ci_abs;
  logic [SQ_W-1:0]  sqr_q, sqi_q, en2_q, den_q;
  logic [ML2_W-1:0] ml2_q;
  logic [MG_W-1:0]  mag2_q;

  assign cr_abs = cr_q[CR_W-1] ? CR_W'(-cr_q) : CR_W'(cr_q);
  assign ci_abs = ci_q[CR_W-1] ? CR_W'(-ci_q) : CR_W'(ci_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sqr_q <= cr_abs[EN_W-1:0] * cr_abs[EN_W-1:0];
      sqi_q <= ci_abs[EN_W-1:0] * ci_abs[EN_W-1:0];
      en2_q <= en_q * en_q;
      ml2_q <= cfg_i.min_level * cfg_i.min_level;
    end
    if (cmd_i.sum) begin
      mag2_q <= MG_W'(sqr_q) + MG_W'(sqi_q);
      den_q  <= en2_q;
    end
  end

  // Restoring divider: floor(4096*|C|^2/E^2), one bit per cycle
  logic                 low_q, sat_q, take;
  logic [DV_W-1:0]      rem_q, dsh_q;
  logic [METRIC_W-1:0]  quo_q, metric_c;
  logic [DIV_CNT_W-1:0] cnt_q;

  assign take              = (rem_q >= dsh_q);
  assign status_o.div_last = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      low_q <= (en_q == '0) || (en_q < cfg_i.min_level) || (mag2_q < ml2_q);
      sat_q <= (mag2_q >= {den_q, {SAT_SH{1'b0}}});
      rem_q <= DV_W'({mag2_q, {Q_FRAC{1'b0}}});
      dsh_q <= DV_W'({den_q, {(METRIC_W-1){1'b0}}});
      quo_q <= '0;
      cnt_q <= DIV_CNT_W'(METRIC_W - 1);
    end else if (cmd_i.div_step) begin
      if (take) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[METRIC_W-2:0], take};
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  assign metric_c = low_q ? '0 : (sat_q ? '1 : quo_q);

  // Detection with holdoff, result register
  logic [HOLD_W-1:0] hold_q;
  logic              det_c;

  assign det_c = (hold_q == '0) && (metric_c > cfg_i.threshold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else if (cmd_i.load_out) begin
      if (hold_q != '0) begin
        hold_q <= hold_q - HOLD_W'(1);
      end else if (det_c) begin
        hold_q <= (cfg_i.holdoff_len == '0) ? '0 : cfg_i.holdoff_len - HOLD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_i_o    <= raw_hold_q[SB-1:0];
      out_q_o    <= raw_hold_q[2*SB-1:SB];
      metric_o   <= metric_c;
      detected_o <= det_c;
      pkt_len_o  <= det_c ? cfg_i.pkt_len_total : '0;
    end
  end

endmodule

@@ hdl/delay_correlate_preamble_detector_top.sv @@
// Top level of the delay-and-correlate preamble detector: stream ports,
// configuration registers. Depends on dcpd_pkg, dcpd_ctrl, dcpd_datapath.
//
// Usage:
//  - Slave stream (s_axis_*): one item per sample, clean and raw I/Q.
//  - Master stream (m_axis_*): one item per input item, the raw sample
//    delayed by window_len+lag-1, the Q4.12 metric, packet length and the
//    detection flag in tuser.
//  - Configuration channel (cfg_*): always ready; index selects window_len,
//    lag, threshold, min_level, holdoff_len, total packet length (0..5).
//    Write it only while no item is in flight.
//  - Sequence: the L history pairs (L = clamped window_len) stream through
//    one multiply-accumulate step; then drain, square, sum and check, the
//    bit-serial metric divider and the result load. A new item is taken
//    only once the last one has been loaded, so items do not overlap.
//  - A stalled result waits in the output register; the next item is still
//    taken and processed, and holds before its load until the register frees.
//  - Reset clears the history (valid bits, reads return zero), the
//    holdoff counter and loads the register defaults. No clearing pass.
module delay_correlate_preamble_detector_top #(
  parameter int unsigned MAX_WINDOW    = 64,
  parameter int unsigned MAX_LAG       = 64,
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned HISTORY_DEPTH = 128,
  localparam int unsigned IN_W  = ((4 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * SAMPLE_BITS + 32 + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // clean_i, clean_q, raw_i, raw_q
  input  logic [IN_W-1:0]                     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // out_i, out_q, metric, pkt_len
  output logic [OUT_W-1:0]                    m_axis_tdata_o,
  // detected
  output logic                                m_axis_tuser_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dcpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dcpd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import dcpd_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  logic [SB-1:0]       out_i, out_q;
  logic [METRIC_W-1:0] metric;
  logic [PLEN_W-1:0]   pkt_len;
  logic                detected;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len    <= WIN_W'(48);
      cfg_q.lag           <= LAG_W'(16);
      cfg_q.threshold     <= THR_W'(3277);
      cfg_q.min_level     <= ML_W'(1);
      cfg_q.holdoff_len   <= HOLD_W'(320);
      cfg_q.pkt_len_total <= PLEN_W'(0);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LEN:  cfg_q.window_len    <= cfg_data_i[WIN_W-1:0];
        CFG_LAG:         cfg_q.lag           <= cfg_data_i[LAG_W-1:0];
        CFG_THRESHOLD:   cfg_q.threshold     <= cfg_data_i[THR_W-1:0];
        CFG_MIN_LEVEL:   cfg_q.min_level     <= cfg_data_i[ML_W-1:0];
        CFG_HOLDOFF_LEN: cfg_q.holdoff_len   <= cfg_data_i[HOLD_W-1:0];
        CFG_PACKET_LEN:  cfg_q.pkt_len_total <= cfg_data_i[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  dcpd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  dcpd_datapath #(
    .MAX_WINDOW    (MAX_WINDOW),
    .MAX_LAG       (MAX_LAG),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .clean_i_i    (s_axis_tdata_i[SB-1:0]),
    .clean_q_i    (s_axis_tdata_i[2*SB-1:SB]),
    .raw_i_i      (s_axis_tdata_i[3*SB-1:2*SB]),
    .raw_q_i      (s_axis_tdata_i[4*SB-1:3*SB]),
    .out_i_o      (out_i),
    .out_q_o      (out_q),
    .metric_o     (metric),
    .detected_o   (detected),
    .pkt_len_o    (pkt_len)
  );

  assign m_axis_tdata_o = OUT_W'({pkt_len, metric, out_q, out_i});
  assign m_axis_tuser_o = detected;

endmodule
